/* design/nsc_pkg.sv */
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types and codes for the NMEA sentence checker.
// ----------------------------------------------------------------------------
`default_nettype none

package nsc_pkg;

    // default length limit of one sentence in bytes
    localparam int MAX_LENGTH_DEF = 128;

    // message type codes
    localparam logic [3:0] MSG_GGA     = 4'd0;
    localparam logic [3:0] MSG_GSA     = 4'd1;
    localparam logic [3:0] MSG_RMC     = 4'd2;
    localparam logic [3:0] MSG_GLL     = 4'd3;
    localparam logic [3:0] MSG_GSV     = 4'd4;
    localparam logic [3:0] MSG_VTG     = 4'd5;
    localparam logic [3:0] MSG_GRS     = 4'd6;
    localparam logic [3:0] MSG_TXT     = 4'd7;
    localparam logic [3:0] MSG_UNKNOWN = 4'd8;
    localparam logic [3:0] MSG_ERROR   = 4'd9;

    // talker class codes
    localparam logic [2:0] SYS_GN      = 3'd0;
    localparam logic [2:0] SYS_GP      = 3'd1;
    localparam logic [2:0] SYS_GL      = 3'd2;
    localparam logic [2:0] SYS_UNKNOWN = 3'd3;
    localparam logic [2:0] SYS_ERROR   = 3'd4;

    // input request payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       sentence_start;
    } in_item_t;

    // result request payload
    typedef struct packed {
        logic [3:0] message_type;
        logic [2:0] gnss_system;
        logic       checksum_ok;
        logic       length_error;
    } out_item_t;

    // result handed from the checking logic to the output register
    typedef struct packed {
        logic      valid;
        out_item_t data;
    } result_req_t;

endpackage

`default_nettype wire

/* design/nsc_in_stage.sv */
// ----------------------------------------------------------------------------
// nsc_in_stage
// Input register: holds one accepted byte until the checking logic takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module nsc_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire nsc_pkg::in_item_t in_data,
    output logic                   in_stall,
    input  wire logic              advance,
    output logic                   item_valid,
    output nsc_pkg::in_item_t      item
);

    logic              valid_reg;
    logic              valid_next;
    nsc_pkg::in_item_t data_reg;
    logic              accept;

    // stall only while a held byte is not consumed this cycle
    assign in_stall = valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= in_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

`default_nettype wire

/* design/nsc_check.sv */
// ----------------------------------------------------------------------------
// nsc_check
// Sentence state, running xor, header capture, checksum decode and
// classification of the talker and message type.
// ----------------------------------------------------------------------------
`default_nettype none

module nsc_check #(
    parameter int MAX_LENGTH = nsc_pkg::MAX_LENGTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire nsc_pkg::in_item_t item,
    input  wire logic              out_free,
    output logic                   advance,
    output nsc_pkg::result_req_t   result
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_CK1  = 2'd2;
    localparam logic [1:0] PH_CK2  = 2'd3;

    localparam logic [7:0] LEN_LIMIT = 8'(MAX_LENGTH - 1);
    localparam logic [7:0] POS_MAX   = 8'hFF;

    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_N    = 8'h4E;
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_L    = 8'h4C;
    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_M    = 8'h4D;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_V    = 8'h56;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_X    = 8'h58;

    // digit value (n / 17) * 10 + n % 17 with n = c - 48; n / 17 is
    // (n * 241) >> 12, exact for every 8-bit n
    function automatic logic [7:0] decode_digit(input logic [7:0] c);
        logic [7:0]  n;
        logic [15:0] prod;
        logic [3:0]  q;
        logic [7:0]  r;
        n    = c - CH_ZERO;
        prod = 16'(n) * 16'd241;
        q    = prod[15:12];
        r    = n - 8'(q) * 8'd17;
        return 8'(q) * 8'd10 + r;
    endfunction

    function automatic logic is3(input logic [4:0][7:0] h, input logic [7:0] a,
                                 input logic [7:0] b, input logic [7:0] c);
        return (h[2] == a) && (h[3] == b) && (h[4] == c);
    endfunction

    function automatic logic [3:0] classify_type(input logic [4:0][7:0] h);
        logic [3:0] t;
        if (is3(h, CH_G, CH_G, CH_A))      t = nsc_pkg::MSG_GGA;
        else if (is3(h, CH_G, CH_S, CH_A)) t = nsc_pkg::MSG_GSA;
        else if (is3(h, CH_R, CH_M, CH_C)) t = nsc_pkg::MSG_RMC;
        else if (is3(h, CH_G, CH_L, CH_L)) t = nsc_pkg::MSG_GLL;
        else if (is3(h, CH_G, CH_S, CH_V)) t = nsc_pkg::MSG_GSV;
        else if (is3(h, CH_V, CH_T, CH_G)) t = nsc_pkg::MSG_VTG;
        else if (is3(h, CH_G, CH_R, CH_S)) t = nsc_pkg::MSG_GRS;
        else if (is3(h, CH_T, CH_X, CH_T)) t = nsc_pkg::MSG_TXT;
        else                               t = nsc_pkg::MSG_UNKNOWN;
        return t;
    endfunction

    function automatic logic [2:0] classify_system(input logic [4:0][7:0] h);
        logic [2:0] s;
        if (h[0] != CH_G)      s = nsc_pkg::SYS_UNKNOWN;
        else if (h[1] == CH_N) s = nsc_pkg::SYS_GN;
        else if (h[1] == CH_P) s = nsc_pkg::SYS_GP;
        else if (h[1] == CH_L) s = nsc_pkg::SYS_GL;
        else                   s = nsc_pkg::SYS_UNKNOWN;
        return s;
    endfunction

    logic [1:0]      phase_reg, phase_next;
    logic [7:0]      pos_reg, pos_next;
    logic [7:0]      xor_reg, xor_next;
    logic [4:0][7:0] hdr_reg, hdr_next;
    logic [7:0]      high_reg, high_next;
    logic [7:0]      pos_inc;
    logic [7:0]      digit;
    logic [7:0]      rec;

    assign advance = item_valid && out_free;
    assign pos_inc = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 8'd1;
    assign digit   = decode_digit(item.data_byte);
    assign rec     = high_reg | digit;

    // next state and result for the byte being consumed
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        xor_next    = xor_reg;
        hdr_next    = hdr_reg;
        high_next   = high_reg;
        result      = '0;
        result.data.message_type = nsc_pkg::MSG_ERROR;
        result.data.gnss_system  = nsc_pkg::SYS_ERROR;
        if (advance)
        begin
            if (item.sentence_start)
            begin
                phase_next = PH_BODY;
                pos_next   = 8'd0;
                xor_next   = 8'd0;
                hdr_next   = '0;
                high_next  = 8'd0;
            end
            else if (phase_reg != PH_IDLE)
            begin
                pos_next = pos_inc;
                // keep header bytes at positions one to five
                if (pos_inc >= 8'd1 && pos_inc <= 8'd5)
                begin
                    hdr_next[3'(pos_inc - 8'd1)] = item.data_byte;
                end
                case (phase_reg)
                    PH_BODY:
                    begin
                        if (item.data_byte == CH_STAR)
                        begin
                            phase_next = PH_CK1;
                        end
                        else
                        begin
                            xor_next = xor_reg ^ item.data_byte;
                            if (pos_inc >= LEN_LIMIT)
                            begin
                                phase_next               = PH_IDLE;
                                result.valid             = 1'b1;
                                result.data.length_error = 1'b1;
                            end
                        end
                    end
                    PH_CK1:
                    begin
                        high_next  = {digit[3:0], 4'b0000};
                        phase_next = PH_CK2;
                    end
                    default:
                    begin
                        phase_next   = PH_IDLE;
                        result.valid = 1'b1;
                        if (rec == xor_reg)
                        begin
                            result.data.message_type = classify_type(hdr_next);
                            result.data.gnss_system  = classify_system(hdr_next);
                            result.data.checksum_ok  = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // sentence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= 8'd0;
            xor_reg   <= 8'd0;
            hdr_reg   <= '0;
            high_reg  <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            xor_reg   <= xor_next;
            hdr_reg   <= hdr_next;
            high_reg  <= high_next;
        end
    end

endmodule

`default_nettype wire

/* design/nsc_out_stage.sv */
// ----------------------------------------------------------------------------
// nsc_out_stage
// Result register toward the downstream side.
// ----------------------------------------------------------------------------
`default_nettype none

module nsc_out_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire nsc_pkg::result_req_t result,
    output logic                      out_free,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output nsc_pkg::out_item_t        out_data
);

    logic               valid_reg;
    logic               valid_next;
    nsc_pkg::out_item_t data_reg;

    // register can take a new result when empty or being drained
    assign out_free   = !valid_reg || !out_stall;
    assign valid_next = out_free ? result.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (out_free && result.valid)
        begin
            data_reg <= result.data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* design/nmea_sentence_checker_core.sv */
// ----------------------------------------------------------------------------
// nmea_sentence_checker_core
// NMEA 0183 sentence checker: running xor checksum, header capture and
// talker / message type classification, one byte per cycle when not stalled.
// ----------------------------------------------------------------------------
//  channel  signals                        direction  payload
//  in       in_valid / in_stall / in_data  into core  data_byte, sentence_start
//  out      out_valid / out_stall / out_data  out     message_type, gnss_system,
//                                                     checksum_ok, length_error
//
//  One byte per cycle while the result side is not stalled; each accepted
//  byte is held in the input register, then its result in the result register.
//  Reset clears the sentence state to idle and empties both registers.
//  A stalled result register holds the byte in the input register, which then
//  stalls the input side; a new byte is taken in the same cycle the held byte
//  moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_checker_core #(
    parameter int MAX_LENGTH = nsc_pkg::MAX_LENGTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire nsc_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output nsc_pkg::out_item_t      out_data
);

    logic                 item_valid;
    nsc_pkg::in_item_t    item;
    logic                 advance;
    logic                 out_free;
    nsc_pkg::result_req_t result;

    // input register
    nsc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .in_stall   (in_stall),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // sentence checking logic
    nsc_check #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .advance    (advance),
        .result     (result)
    );

    // result register
    nsc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    // a length error always carries the error codes
    a_len_err_codes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.length_error |->
            out_data.message_type == nsc_pkg::MSG_ERROR &&
            out_data.gnss_system == nsc_pkg::SYS_ERROR && !out_data.checksum_ok)
        else $error("length error result without error codes");

    // checksum flag agrees with the error code of the message type
    a_ck_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.checksum_ok == (out_data.message_type != nsc_pkg::MSG_ERROR))
        else $error("checksum flag and message type disagree");

    // input stalls only while a byte is held and the result side is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> item_valid && out_valid && out_stall)
        else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire
